// ===== design/stationary_foreground_history_core_macros.svh =====
// Assertion macros for the stationary foreground history core.
`ifndef STATIONARY_FOREGROUND_HISTORY_CORE_MACROS_SVH
`define STATIONARY_FOREGROUND_HISTORY_CORE_MACROS_SVH
`ifndef SYNTH
`define SFH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfh: same-cycle check failed");
`define SFH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfh: next-cycle check failed");
`else
`define SFH_ASSERT_IMP(lbl, ante, cons)
`define SFH_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/sfh_pkg.sv =====
// Shared constants, types and register codes of the stationary foreground history core.
`timescale 1ns / 1ps
package sfh_pkg;

  localparam int PIXEL_COUNT  = 131072;
  localparam int HISTORY_BITS = 20;

  localparam int IDX_W   = 17;
  localparam int VAL_W   = 8;
  localparam int OUT_H_W = 20;
  localparam int ADDR_W  = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int HIST_W  = HISTORY_BITS;

  localparam int COST_W  = 4;
  localparam int FRM_W   = 12;
  localparam int THR_W   = 9;
  localparam int PROD_W  = COST_W + VAL_W;
  localparam int FRM255_W = FRM_W + 8;
  localparam int RHS_W   = THR_W + FRM255_W;
  localparam int SUM_W   = ((HIST_W > PROD_W) ? HIST_W : PROD_W) + 1;
  localparam int LHS_W   = HIST_W + 8;
  localparam int CMP_W   = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [THR_W-1:0] THR_ONE = THR_W'(256);

  typedef enum logic [1:0] {
    REG_INC_COST  = 2'd0,
    REG_DEC_COST  = 2'd1,
    REG_FRAMES    = 2'd2,
    REG_THRESHOLD = 2'd3
  } sfh_reg_t;

  // Configuration as seen by the update pipeline.
  typedef struct packed {
    logic [COST_W-1:0] inc_cost;
    logic [COST_W-1:0] dec_cost;
    logic [RHS_W-1:0]  rhs;
    logic              thr_ok;
  } sfh_cfg_t;

  // Pipeline status for the top level.
  typedef struct packed {
    logic clr_busy;
    logic s1_valid;
    logic out_valid;
  } sfh_stat_t;

endpackage

// ===== design/sfh_stream_if.sv =====
// Valid/ready channel interfaces for pixel beats in and result beats out.
`timescale 1ns / 1ps
interface sfh_pix_in_if;
  logic                      valid;
  logic                      ready;
  logic [sfh_pkg::IDX_W-1:0] pixel_index;
  logic [sfh_pkg::VAL_W-1:0] pixel_value;
  modport source(output valid, output pixel_index, output pixel_value, input ready);
  modport sink(input valid, input pixel_index, input pixel_value, output ready);
endinterface

interface sfh_pix_out_if;
  logic                        valid;
  logic                        ready;
  logic                        stationary;
  logic [sfh_pkg::OUT_H_W-1:0] history_value;
  modport source(output valid, output stationary, output history_value, input ready);
  modport sink(input valid, input stationary, input history_value, output ready);
endinterface

// ===== design/sfh_cfg_regs.sv =====
// APB configuration registers and the precomputed stationarity bound.
`timescale 1ns / 1ps
module sfh_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfh_pkg::PADDR_W-1:0]  paddr,
  input  logic [sfh_pkg::PDATA_W-1:0]  pwdata,
  output logic [sfh_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output sfh_pkg::sfh_cfg_t            cfg
);

  logic [sfh_pkg::COST_W-1:0]   inc_r;
  logic [sfh_pkg::COST_W-1:0]   dec_r;
  logic [sfh_pkg::FRM_W-1:0]    frm_r;
  logic [sfh_pkg::THR_W-1:0]    thr_r;
  logic [sfh_pkg::RHS_W-1:0]    rhs_r;
  logic                         thr_ok_r;
  logic [sfh_pkg::FRM255_W-1:0] frm255;
  logic [sfh_pkg::RHS_W-1:0]    rhs_nxt;
  logic                         wr_en;
  sfh_pkg::sfh_reg_t            reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = sfh_pkg::sfh_reg_t'(paddr[3:2]);

  // frames * 255 as a shift and subtract.
  assign frm255  = {frm_r, 8'd0} - sfh_pkg::FRM255_W'(frm_r);
  assign rhs_nxt = sfh_pkg::RHS_W'(thr_r) * sfh_pkg::RHS_W'(frm255);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r <= sfh_pkg::COST_W'(1);
      dec_r <= sfh_pkg::COST_W'(4);
      frm_r <= sfh_pkg::FRM_W'(125);
      thr_r <= sfh_pkg::THR_W'(128);
    end else if (wr_en) begin
      unique case (reg_sel)
        sfh_pkg::REG_INC_COST:  inc_r <= pwdata[sfh_pkg::COST_W-1:0];
        sfh_pkg::REG_DEC_COST:  dec_r <= pwdata[sfh_pkg::COST_W-1:0];
        sfh_pkg::REG_FRAMES:    frm_r <= pwdata[sfh_pkg::FRM_W-1:0];
        sfh_pkg::REG_THRESHOLD: thr_r <= pwdata[sfh_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // The bound is registered from the registers, so it follows them in the next cycle.
  always_ff @(posedge clk) begin
    rhs_r    <= rhs_nxt;
    thr_ok_r <= (thr_r <= sfh_pkg::THR_ONE);
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      sfh_pkg::REG_INC_COST:  prdata = sfh_pkg::PDATA_W'(inc_r);
      sfh_pkg::REG_DEC_COST:  prdata = sfh_pkg::PDATA_W'(dec_r);
      sfh_pkg::REG_FRAMES:    prdata = sfh_pkg::PDATA_W'(frm_r);
      sfh_pkg::REG_THRESHOLD: prdata = sfh_pkg::PDATA_W'(thr_r);
      default:                prdata = '0;
    endcase
  end

  assign cfg.inc_cost = inc_r;
  assign cfg.dec_cost = dec_r;
  assign cfg.rhs      = rhs_r;
  assign cfg.thr_ok   = thr_ok_r;

endmodule

// ===== design/sfh_update_pipe.sv =====
// History memory with clearing pass, read-modify-write pipeline and result register.
`timescale 1ns / 1ps
module sfh_update_pipe (
  input  logic              clk,
  input  logic              rst_n,
  sfh_pix_in_if.sink        in_s,
  sfh_pix_out_if.source     out_s,
  input  sfh_pkg::sfh_cfg_t cfg,
  output sfh_pkg::sfh_stat_t st
);

  logic [sfh_pkg::HIST_W-1:0] mem [sfh_pkg::PIXEL_COUNT];

  logic                        clr_busy_r;
  logic [sfh_pkg::ADDR_W-1:0]  clr_cnt_r;

  logic                        s1_v_r;
  logic [sfh_pkg::ADDR_W-1:0]  s1_addr_r;
  logic                        s1_rng_r;
  logic [sfh_pkg::PROD_W-1:0]  s1_incv_r;
  logic [sfh_pkg::PROD_W-1:0]  s1_decv_r;
  logic [sfh_pkg::HIST_W-1:0]  rd_r;

  logic                        lw_v_r;
  logic [sfh_pkg::ADDR_W-1:0]  lw_addr_r;
  logic [sfh_pkg::HIST_W-1:0]  lw_h_r;

  logic                        out_v_r;
  logic                        out_stat_r;
  logic [sfh_pkg::OUT_H_W-1:0] out_hist_r;

  logic                        accept;
  logic                        s1_go;
  logic [sfh_pkg::ADDR_W-1:0]  in_addr;
  logic                        in_rng;
  logic [sfh_pkg::VAL_W-1:0]   bg_val;
  logic [sfh_pkg::HIST_W-1:0]  old_h;
  logic [sfh_pkg::SUM_W-1:0]   up;
  logic [sfh_pkg::SUM_W-1:0]   down;
  logic [sfh_pkg::SUM_W-1:0]   h_raw;
  logic [sfh_pkg::HIST_W-1:0]  h_new;
  logic [sfh_pkg::CMP_W-1:0]   lhs;
  logic                        stat_new;
  logic                        mem_we;
  logic [sfh_pkg::ADDR_W-1:0]  mem_wa;
  logic [sfh_pkg::HIST_W-1:0]  mem_wd;

  assign s1_go      = s1_v_r && (!out_v_r || out_s.ready);
  assign in_s.ready = !clr_busy_r && (!s1_v_r || s1_go);
  assign accept     = in_s.valid && in_s.ready;

  assign in_addr = sfh_pkg::ADDR_W'(in_s.pixel_index);
  assign in_rng  = ({1'b0, in_s.pixel_index} < (sfh_pkg::IDX_W + 1)'(sfh_pkg::PIXEL_COUNT));
  assign bg_val  = ~in_s.pixel_value;

  // A write at the same edge as a read of that entry is not seen by the read,
  // so the last write is forwarded.
  always_comb begin
    old_h = rd_r;
    if (lw_v_r && (lw_addr_r == s1_addr_r)) begin
      old_h = lw_h_r;
    end
    if (!s1_rng_r) begin
      old_h = '0;
    end
  end

  assign up    = sfh_pkg::SUM_W'(old_h) + sfh_pkg::SUM_W'(s1_incv_r);
  assign down  = sfh_pkg::SUM_W'(s1_decv_r);
  assign h_raw = (up > down) ? (up - down) : '0;
  assign h_new = (h_raw > sfh_pkg::SUM_W'({sfh_pkg::HIST_W{1'b1}})) ?
                 {sfh_pkg::HIST_W{1'b1}} : h_raw[sfh_pkg::HIST_W-1:0];
  assign lhs      = sfh_pkg::CMP_W'({h_new, 8'd0});
  assign stat_new = cfg.thr_ok && (lhs >= sfh_pkg::CMP_W'(cfg.rhs));

  assign mem_we = clr_busy_r || (s1_go && s1_rng_r);
  assign mem_wa = clr_busy_r ? clr_cnt_r : s1_addr_r;
  assign mem_wd = clr_busy_r ? '0 : h_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (accept) begin
      rd_r <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      s1_v_r     <= 1'b0;
      lw_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == sfh_pkg::ADDR_W'(sfh_pkg::PIXEL_COUNT - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go && s1_rng_r) begin
        lw_v_r <= 1'b1;
      end
      if (s1_go) begin
        out_v_r <= 1'b1;
      end else if (out_s.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r <= in_addr;
      s1_rng_r  <= in_rng;
      s1_incv_r <= sfh_pkg::PROD_W'(cfg.inc_cost) * sfh_pkg::PROD_W'(in_s.pixel_value);
      s1_decv_r <= sfh_pkg::PROD_W'(cfg.dec_cost) * sfh_pkg::PROD_W'(bg_val);
    end
    if (s1_go && s1_rng_r) begin
      lw_addr_r <= s1_addr_r;
      lw_h_r    <= h_new;
    end
    if (s1_go) begin
      out_stat_r <= stat_new;
      out_hist_r <= sfh_pkg::OUT_H_W'(h_new);
    end
  end

  assign out_s.valid         = out_v_r;
  assign out_s.stationary    = out_stat_r;
  assign out_s.history_value = out_hist_r;

  assign st.clr_busy  = clr_busy_r;
  assign st.s1_valid  = s1_v_r;
  assign st.out_valid = out_v_r;

endmodule

// ===== design/stationary_foreground_history_core.sv =====
// Top level of the stationary foreground history core.
// Takes one mask pixel beat per clock while the output does not stall and returns
// one result beat per pixel: the pixel's updated history count (clamped at zero,
// saturated at the store's maximum) and a stationary flag. After reset the history
// memory is cleared one entry per cycle; no pixel is taken during that pass, while
// register writes are. After that the block sustains one pixel per clock while the
// output does not stall: the history memory is read as the pixel is taken, updated
// in the update stage and written back as that stage advances, and the result then
// sits in an output register until it is accepted.
// Back-to-back pixels at the same index are served by forwarding the last write.
// Input ready depends combinationally on output ready.
`timescale 1ns / 1ps
`include "stationary_foreground_history_core_macros.svh"
module stationary_foreground_history_core (
  input  logic                        clk,
  input  logic                        rst_n,
  sfh_pix_in_if.sink                  in_s,
  sfh_pix_out_if.source               out_s,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfh_pkg::PADDR_W-1:0] paddr,
  input  logic [sfh_pkg::PDATA_W-1:0] pwdata,
  output logic [sfh_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  sfh_pkg::sfh_cfg_t  cfg;
  sfh_pkg::sfh_stat_t st;

  sfh_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfh_update_pipe u_pipe (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_s),
    .out_s (out_s),
    .cfg   (cfg),
    .st    (st)
  );

  // No pixel is taken and no result is offered while the memory is cleared.
  `SFH_ASSERT_IMP(a_clr_no_accept, st.clr_busy, !in_s.ready)
  `SFH_ASSERT_IMP(a_clr_no_result, st.clr_busy, !st.out_valid && !st.s1_valid)
  // An accepted beat always occupies the update stage on the next cycle.
  `SFH_ASSERT_NXT(a_accept_to_s1, in_s.valid && in_s.ready, st.s1_valid)

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the stationary foreground history core: predicts every result beat and checks it.
`timescale 1ns / 1ps
module tb_top;

  // The clearing pass after reset visits every history entry with no beat taken.
  localparam int WATCHDOG_LIMIT = 4 * sfh_pkg::PIXEL_COUNT;
  localparam longint unsigned FULL_FG = 255;
  localparam longint unsigned HIST_MAX = (64'd1 << sfh_pkg::HIST_W) - 1;

  typedef struct packed {
    logic [sfh_pkg::IDX_W-1:0] idx;
    logic [sfh_pkg::VAL_W-1:0] val;
  } pixel_beat_t;

  typedef struct packed {
    logic                        stationary;
    logic [sfh_pkg::OUT_H_W-1:0] history;
  } history_result_t;

  logic                        clk;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [sfh_pkg::PADDR_W-1:0] paddr;
  logic [sfh_pkg::PDATA_W-1:0] pwdata;
  logic [sfh_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  sfh_pix_in_if  in_if ();
  sfh_pix_out_if out_if ();

  stationary_foreground_history_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_s    (in_if.sink),
    .out_s   (out_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Testbench copy of the registers and of the history memory.
  logic [sfh_pkg::COST_W-1:0] inc_cost_q;
  logic [sfh_pkg::COST_W-1:0] dec_cost_q;
  logic [sfh_pkg::FRM_W-1:0]  frames_q;
  logic [sfh_pkg::THR_W-1:0]  thr_q;
  bit   [sfh_pkg::HIST_W-1:0] history_mem [sfh_pkg::PIXEL_COUNT];

  pixel_beat_t     pixel_q[$];
  history_result_t expected_q[$];
  int              pending_results;
  int              err_count;
  int              idle_cycles;
  int              send_idle_pct;
  int              stall_pct;
  logic [sfh_pkg::IDX_W-1:0] hot_idx [4];

  function automatic history_result_t update_history(input logic [sfh_pkg::IDX_W-1:0] idx,
                                                     input logic [sfh_pkg::VAL_W-1:0] val);
    longint unsigned prior;
    longint unsigned up;
    longint unsigned down;
    longint unsigned h;
    longint unsigned rhs;
    history_result_t r;
    prior = (idx < sfh_pkg::PIXEL_COUNT) ? 64'(history_mem[idx]) : 64'd0;
    up    = prior + 64'(inc_cost_q) * 64'(val);
    down  = 64'(dec_cost_q) * (FULL_FG - 64'(val));
    h     = (up <= down) ? 64'd0 : up - down;
    if (h > HIST_MAX) h = HIST_MAX;
    if (idx < sfh_pkg::PIXEL_COUNT) history_mem[idx] = h[sfh_pkg::HIST_W-1:0];
    // A threshold above one can never be reached since the fraction is capped at one.
    rhs = 64'(thr_q) * FULL_FG * 64'(frames_q);
    r.stationary = (thr_q <= sfh_pkg::THR_ONE) && (h * 256 >= rhs);
    r.history    = h[sfh_pkg::OUT_H_W-1:0];
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Pixel beat driver.
  always @(posedge clk) begin : pixel_driver
    pixel_beat_t b;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready)
        expected_q.insert(expected_q.size(),
                          update_history(in_if.pixel_index, in_if.pixel_value));
      if (!in_if.valid || in_if.ready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          b = pixel_q.pop_front();
          in_if.valid       <= 1'b1;
          in_if.pixel_index <= b.idx;
          in_if.pixel_value <= b.val;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result beat monitor.
  always @(posedge clk) begin : result_monitor
    history_result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: stationary=%0b history=%0d",
                   $time, out_if.stationary, out_if.history_value);
          err_count++;
        end else begin
          want = expected_q.pop_front();
          pending_results--;
          if (want.stationary !== out_if.stationary) begin
            $display("%0t: stationary mismatch: expected %0b actual %0b",
                     $time, want.stationary, out_if.stationary);
            err_count++;
          end
          if (want.history !== out_if.history_value) begin
            $display("%0t: history_value mismatch: expected %0d actual %0d",
                     $time, want.history, out_if.history_value);
            err_count++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_pixel(input logic [sfh_pkg::IDX_W-1:0] idx,
                           input logic [sfh_pkg::VAL_W-1:0] val);
    pixel_beat_t b;
    b.idx = idx;
    b.val = val;
    pixel_q.insert(pixel_q.size(), b);
    pending_results++;
  endtask

  // Most beats hit a few hot pixels with mask-like values so that histories build up;
  // the rest are arbitrary pixels and values.
  task automatic add_random_pixels(input int n, input int pool_n, input int shaped_pct,
                                   input int fg_pct);
    int k;
    int r;
    logic [sfh_pkg::IDX_W-1:0] idx;
    logic [sfh_pkg::VAL_W-1:0] val;
    for (k = 0; k < pool_n; k++)
      hot_idx[k] = sfh_pkg::IDX_W'($urandom_range(sfh_pkg::PIXEL_COUNT - 1));
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99) < shaped_pct) begin
        idx = hot_idx[$urandom_range(pool_n - 1)];
        r   = int'($urandom_range(99));
        if (r < fg_pct) val = 8'd255;
        else if (r < 90) val = 8'd0;
        else val = sfh_pkg::VAL_W'($urandom_range(255));
      end else begin
        idx = sfh_pkg::IDX_W'($urandom_range(sfh_pkg::PIXEL_COUNT - 1));
        val = sfh_pkg::VAL_W'($urandom_range(255));
      end
      add_pixel(idx, val);
    end
  endtask

  task automatic wait_idle();
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input sfh_pkg::sfh_reg_t r, input int d);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= sfh_pkg::PADDR_W'({r, 2'b00});
    pwdata  <= sfh_pkg::PDATA_W'(d);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (r)
      sfh_pkg::REG_INC_COST:  inc_cost_q = sfh_pkg::COST_W'(d);
      sfh_pkg::REG_DEC_COST:  dec_cost_q = sfh_pkg::COST_W'(d);
      sfh_pkg::REG_FRAMES:    frames_q   = sfh_pkg::FRM_W'(d);
      sfh_pkg::REG_THRESHOLD: thr_q      = sfh_pkg::THR_W'(d);
      default: ;
    endcase
  endtask

  task automatic set_config(input int inc, input int dec, input int frames, input int thr);
    wait_idle();
    write_reg(sfh_pkg::REG_INC_COST, inc);
    write_reg(sfh_pkg::REG_DEC_COST, dec);
    write_reg(sfh_pkg::REG_FRAMES, frames);
    write_reg(sfh_pkg::REG_THRESHOLD, thr);
  endtask

  initial begin
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_if.valid       = 1'b0;
    in_if.pixel_index = '0;
    in_if.pixel_value = '0;
    out_if.ready      = 1'b0;
    inc_cost_q        = 4'd1;
    dec_cost_q        = 4'd4;
    frames_q          = 12'd125;
    thr_q             = 9'd128;
    pending_results   = 0;
    err_count         = 0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: first and last pixel, clamping at zero, repeated pixel back to back.
    add_pixel(17'd0, 8'd255);
    add_pixel(17'd0, 8'd255);
    add_pixel(17'd0, 8'd0);
    add_pixel(17'h1FFFF, 8'd255);
    add_pixel(17'h1FFFF, 8'd1);
    add_pixel(17'h0AAAA, 8'h55);
    add_pixel(17'h15555, 8'hAA);
    add_pixel(17'h15555, 8'd254);

    // Zero frames: the fraction counts as one, so every pixel is stationary.
    set_config(15, 15, 0, int'(sfh_pkg::THR_ONE));
    add_pixel(17'd5, 8'd255);
    add_pixel(17'd5, 8'd255);
    add_pixel(17'd5, 8'd0);
    add_pixel(17'd5, 8'd0);
    add_pixel(17'h1FFFF, 8'd128);

    // Thresholds above one never fire.
    set_config(15, 0, 4095, 511);
    add_pixel(17'd9, 8'd255);
    add_pixel(17'd9, 8'd255);
    set_config(15, 0, 4095, 257);
    add_pixel(17'd9, 8'd255);

    // Zero costs leave the history where it was.
    set_config(0, 0, 1, 1);
    add_pixel(17'd5, 8'd0);
    add_pixel(17'h1FFFF, 8'd255);
    add_pixel(17'd9, 8'd0);

    set_config($urandom_range(15, 1), $urandom_range(15), $urandom_range(4, 1),
               $urandom_range(256));
    add_random_pixels(180, 4, 80, 50);

    // One hot pixel driven into saturation, where the flag flips just below the maximum.
    set_config(15, 15, 4095, int'(sfh_pkg::THR_ONE));
    send_idle_pct = 71;
    add_random_pixels(340, 1, 95, 95);

    set_config($urandom_range(15), $urandom_range(15), $urandom_range(16, 1),
               $urandom_range(256));
    send_idle_pct = 0;
    stall_pct     = 71;
    add_random_pixels(180, 4, 70, 50);

    set_config($urandom_range(15), 15, 1, 0);
    send_idle_pct = 38;
    stall_pct     = 38;
    add_random_pixels(150, 4, 70, 60);

    wait_idle();
    repeat (8) @(posedge clk);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/sfh_pkg.sv
design/sfh_stream_if.sv
design/sfh_cfg_regs.sv
design/sfh_update_pipe.sv
design/stationary_foreground_history_core.sv
bench/tb_top.sv
